// ===== src/erpt_pkg.sv =====
// Shared types, constants and the elaboration-time sine table generator
// for the Euler rotation point transform. No dependencies.
`default_nettype none

package erpt_pkg;

   localparam int ANGLE_BITS_DEF = 12;
   localparam int COORD_BITS_DEF = 32;

   localparam int APB_DATA_BITS = 32;
   localparam int APB_ADDR_BITS = 4;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_ZENITH  = 2'd1;
   localparam logic [1:0] REG_AZIMUTH = 2'd2;

   localparam int MAT_BITS    = 18;
   localparam int MAT_ENTRIES = 9;
   localparam int ROM_BITS    = 17;
   localparam int ONE_Q16     = 65536;
   localparam int HALF_LSB    = 32768;

   typedef logic signed [MAT_BITS-1:0] mat_entry_type;

   typedef struct packed {
      logic start;
      logic mode;
   } rebuild_req_type;

   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

   // (a*b) >> 60 for operands below 2^62
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] al, ah, bl, bh, ll, m1, m2, hh, t, lo, hi;
      al = {32'd0, a[31:0]};
      ah = {32'd0, a[63:32]};
      bl = {32'd0, b[31:0]};
      bh = {32'd0, b[63:32]};
      ll = al * bl;
      m1 = al * bh;
      m2 = ah * bl;
      hh = ah * bh;
      t  = (ll >> 32) + {32'd0, m1[31:0]} + {32'd0, m2[31:0]};
      lo = {32'd0, ll[31:0]} | (t << 32);
      hi = hh + (m1 >> 32) + (m2 >> 32) + (t >> 32);
      return (hi << 4) | (lo >> 60);
   endfunction

   // round(65536*sin(pi/2 * k / 2^qtr_bits)); evaluated only at elaboration
   function automatic logic [ROM_BITS-1:0] sin_rom_entry(input int k, input int qtr_bits);
      logic [63:0] x, x2, term, sum, rounded;
      x    = mul_q60(HALF_PI_Q60, 64'(k) << (60 - qtr_bits));
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n < 40; n++) begin
         if (term != 64'd0) begin
            term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      rounded = (sum + (64'd1 << 43)) >> 44;
      return rounded[ROM_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/erpt_matrix_gen.sv =====
// Matrix rebuild sequencer: quarter-wave sine ROM, one shared 18x18
// multiplier and the 3x3 matrix registers. Depends on erpt_pkg.
`default_nettype none

module erpt_matrix_gen
   import erpt_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rebuild_req_type       rebuild,
   input  logic [ANGLE_BITS-1:0] zenith,
   input  logic [ANGLE_BITS-1:0] azimuth,
   output logic                  busy,
   output mat_entry_type         matrix [MAT_ENTRIES]
);

   localparam int QTR_BITS = ANGLE_BITS - 2;
   localparam int QTR_SIZE = 1 << QTR_BITS;
   localparam int ROM_AW   = QTR_BITS + 1;
   localparam int STEP_W   = 4;
   localparam int PROD_W   = 2 * MAT_BITS;

   // sequence: ROM reads 0..3, trig capture 1..4, multiply 5..8,
   // round capture 6..9, matrix write 10
   localparam logic [STEP_W-1:0] STEP_ROM_LAST  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_TRIG_1ST  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_TRIG_LAST = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_MUL_1ST   = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_RND_1ST   = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_RND_LAST  = STEP_W'(9);
   localparam logic [STEP_W-1:0] STEP_WRITE     = STEP_W'(10);

   localparam int TRIG_SB = 0;
   localparam int TRIG_CB = 1;
   localparam int TRIG_SG = 2;
   localparam int TRIG_CG = 3;

   // rounded products: cB*cG, cB*sG, sB*cG, sB*sG
   localparam int RND_CBCG = 0;
   localparam int RND_CBSG = 1;
   localparam int RND_SBCG = 2;
   localparam int RND_SBSG = 3;

   logic [ROM_BITS-1:0] rom_table [QTR_SIZE+1];

   for (genvar k = 0; k <= QTR_SIZE; k++) begin : g_rom
      localparam logic [ROM_BITS-1:0] ENTRY = sin_rom_entry(k, QTR_BITS);
      assign rom_table[k] = ENTRY;
   end

   logic                  busy_ff, busy_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   mat_entry_type         matrix_ff [MAT_ENTRIES];
   mat_entry_type         matrix_in [MAT_ENTRIES];
   logic [ROM_BITS-1:0]   rom_data_ff;
   logic                  neg_ff;
   mat_entry_type         trig_ff [4];
   mat_entry_type         rnd_ff [4];
   logic signed [PROD_W-1:0] prod_ff;

   logic [ANGLE_BITS-1:0] angle_sel, angle_adj;
   logic [1:0]            quad;
   logic [ROM_AW-1:0]     rom_addr;
   mat_entry_type         trig_val, op_a, op_b, rnd_val;
   logic [STEP_W-1:0]     trig_idx, mul_idx, rnd_idx;
   logic signed [PROD_W-1:0] prod_round;

   // ROM address: sine for even steps, cosine (angle + quarter turn) for odd
   always_comb begin
      angle_sel = step_ff[1] ? azimuth : zenith;
      angle_adj = step_ff[0] ? angle_sel + ANGLE_BITS'(QTR_SIZE) : angle_sel;
      quad      = angle_adj[ANGLE_BITS-1 -: 2];
      rom_addr  = quad[0] ? ROM_AW'(QTR_SIZE) - {1'b0, angle_adj[QTR_BITS-1:0]}
                          : {1'b0, angle_adj[QTR_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= rom_table[rom_addr];
      neg_ff      <= quad[1];
   end

   always_comb begin
      trig_val = neg_ff ? -$signed({1'b0, rom_data_ff}) : $signed({1'b0, rom_data_ff});
      trig_idx = step_ff - STEP_TRIG_1ST;
      mul_idx  = step_ff - STEP_MUL_1ST;
      rnd_idx  = step_ff - STEP_RND_1ST;
      op_a     = mul_idx[1] ? trig_ff[TRIG_SB] : trig_ff[TRIG_CB];
      op_b     = mul_idx[0] ? trig_ff[TRIG_SG] : trig_ff[TRIG_CG];
      prod_round = prod_ff + PROD_W'(HALF_LSB);
      rnd_val  = mat_entry_type'(prod_round >>> 16);
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      if (busy_ff && step_ff >= STEP_TRIG_1ST && step_ff <= STEP_TRIG_LAST) begin
         trig_ff[trig_idx[1:0]] <= trig_val;
      end
      if (busy_ff && step_ff >= STEP_RND_1ST && step_ff <= STEP_RND_LAST) begin
         rnd_ff[rnd_idx[1:0]] <= rnd_val;
      end
   end

   always_comb begin
      if (!rebuild.mode) begin
         matrix_in[0] = rnd_ff[RND_CBCG];
         matrix_in[1] = -rnd_ff[RND_CBSG];
         matrix_in[2] = trig_ff[TRIG_SB];
         matrix_in[3] = trig_ff[TRIG_SG];
         matrix_in[4] = trig_ff[TRIG_CG];
         matrix_in[5] = '0;
         matrix_in[6] = -rnd_ff[RND_SBCG];
         matrix_in[7] = rnd_ff[RND_SBSG];
         matrix_in[8] = trig_ff[TRIG_CB];
      end else begin
         matrix_in[0] = trig_ff[TRIG_CG];
         matrix_in[1] = '0;
         matrix_in[2] = trig_ff[TRIG_SG];
         matrix_in[3] = rnd_ff[RND_SBSG];
         matrix_in[4] = trig_ff[TRIG_CB];
         matrix_in[5] = -rnd_ff[RND_SBCG];
         matrix_in[6] = -rnd_ff[RND_CBSG];
         matrix_in[7] = trig_ff[TRIG_SB];
         matrix_in[8] = rnd_ff[RND_CBCG];
      end
   end

   // a new request restarts the sequence with the latest registers
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (rebuild.start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff == STEP_WRITE) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         for (int k = 0; k < MAT_ENTRIES; k++) begin
            matrix_ff[k] <= (k == 0 || k == 4 || k == 8) ? MAT_BITS'(ONE_Q16) : '0;
         end
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         if (busy_ff && !rebuild.start && step_ff == STEP_WRITE) begin
            matrix_ff <= matrix_in;
         end
      end
   end

   assign busy   = busy_ff;
   assign matrix = matrix_ff;

   a_start_begins_sequence: assert property (@(posedge clock) disable iff (reset)
      rebuild.start |=> busy_ff && step_ff == '0)
      else $error("rebuild request did not restart the sequencer");

   a_write_ends_sequence: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == STEP_WRITE && !rebuild.start |=> !busy_ff)
      else $error("sequencer stayed busy after the matrix write");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= STEP_WRITE && !(step_ff > STEP_ROM_LAST && step_ff == '0))
      else $error("sequencer step out of range");

endmodule

`default_nettype wire

// ===== src/euler_rotation_point_transform_core.sv =====
// An input transfer reaches rsp_valid through three register stages: multiply,
// sum and round/saturate. One point per cycle is sustained unless rsp_stall or a
// register write holds it; per-stage valid bits fill bubbles while an output waits.
// A write to the mode, zenith or azimuth register holds req_stall while the matrix
// is rebuilt from the sine ROM through one shared 18x18 multiplier.
// Reset (synchronous): identity matrix, registers zero, pipeline empty.
`default_nettype none

module euler_rotation_point_transform_core
   import erpt_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_x_in,
   input  logic signed [COORD_BITS-1:0] req_y_in,
   input  logic signed [COORD_BITS-1:0] req_z_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_x_out,
   output logic signed [COORD_BITS-1:0] rsp_y_out,
   output logic signed [COORD_BITS-1:0] rsp_z_out,
   output logic                         rsp_saturated,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [APB_ADDR_BITS-1:0]     paddr,
   input  logic [APB_DATA_BITS-1:0]     pwdata,
   output logic [APB_DATA_BITS-1:0]     prdata,
   output logic                         pready
);

   localparam int W      = COORD_BITS;
   localparam int PROD_W = W + MAT_BITS;
   localparam int SUM_W  = W + MAT_BITS + 2;
   localparam int RND_W  = SUM_W - 16;
   localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

   // ---------------- configuration ----------------
   logic                  mode_ff;
   logic [ANGLE_BITS-1:0] zenith_ff, azimuth_ff;
   logic                  cfg_wr;
   logic [1:0]            cfg_idx;
   rebuild_req_type       rebuild;
   logic                  gen_busy;
   mat_entry_type         matrix [MAT_ENTRIES];

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         zenith_ff  <= '0;
         azimuth_ff <= '0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_MODE:    mode_ff    <= pwdata[0];
            REG_ZENITH:  zenith_ff  <= pwdata[ANGLE_BITS-1:0];
            REG_AZIMUTH: azimuth_ff <= pwdata[ANGLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rebuild.mode  = mode_ff;
      rebuild.start = 1'b0;
      if (cfg_wr) begin
         unique case (cfg_idx)
            REG_MODE, REG_ZENITH, REG_AZIMUTH: rebuild.start = 1'b1;
            default:                           rebuild.start = 1'b0;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_MODE:    prdata = APB_DATA_BITS'(mode_ff);
         REG_ZENITH:  prdata = APB_DATA_BITS'(zenith_ff);
         REG_AZIMUTH: prdata = APB_DATA_BITS'(azimuth_ff);
         default:     prdata = '0;
      endcase
   end

   erpt_matrix_gen #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_matrix_gen (
      .clock   (clock),
      .reset   (reset),
      .rebuild (rebuild),
      .zenith  (zenith_ff),
      .azimuth (azimuth_ff),
      .busy    (gen_busy),
      .matrix  (matrix)
   );

   // ---------------- datapath pipeline ----------------
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ld1, ld2, ld3;
   logic req_xfer;

   logic signed [W-1:0]      coord [3];
   logic signed [PROD_W-1:0] prod_ff [MAT_ENTRIES];
   logic signed [PROD_W-1:0] prod_in [MAT_ENTRIES];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic signed [W-1:0]      res_ff [3];
   logic signed [W-1:0]      res_in [3];
   logic                     sat_ff, sat_in;
   logic signed [RND_W-1:0]  rnd [3];
   logic [RND_W-W:0]         upper [3];
   logic [2:0]               ovf;

   assign coord[0] = req_x_in;
   assign coord[1] = req_y_in;
   assign coord[2] = req_z_in;

   // a stage loads when empty or when the stage after it moves on
   assign ld3       = !v3_ff || !rsp_stall;
   assign ld2       = !v2_ff || ld3;
   assign ld1       = !v1_ff || ld2;
   assign req_stall = !ld1 || gen_busy || cfg_wr;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      v1_in = ld1 ? req_xfer : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i*3+j] = PROD_W'(coord[j]) * PROD_W'(matrix[i*3+j]);
         end
      end
      // whole sum rounded once, half up
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_W'(prod_ff[i*3]) + SUM_W'(prod_ff[i*3+1])
                   + SUM_W'(prod_ff[i*3+2]) + SUM_W'(HALF_LSB);
      end
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rnd[i]   = $signed(sum_ff[i][SUM_W-1:16]);
         upper[i] = rnd[i][RND_W-1:W-1];
         ovf[i]   = !(&upper[i] || ~|upper[i]);
         if (ovf[i]) begin
            res_in[i] = rnd[i][RND_W-1] ? C_MIN : C_MAX;
         end else begin
            res_in[i] = rnd[i][W-1:0];
         end
         sat_in = sat_in | ovf[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         prod_ff <= prod_in;
      end
      if (ld2) begin
         sum_ff <= sum_in;
      end
      if (ld3) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_x_out     = res_ff[0];
   assign rsp_y_out     = res_ff[1];
   assign rsp_z_out     = res_ff[2];
   assign rsp_saturated = sat_ff;

   a_write_starts_rebuild: assert property (@(posedge clock) disable iff (reset)
      cfg_wr && (cfg_idx == REG_MODE || cfg_idx == REG_ZENITH || cfg_idx == REG_AZIMUTH)
      |=> gen_busy)
      else $error("register write did not start a matrix rebuild");

   a_sat_means_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_x_out == C_MAX || rsp_x_out == C_MIN || rsp_y_out == C_MAX ||
         rsp_y_out == C_MIN || rsp_z_out == C_MAX || rsp_z_out == C_MIN)
      else $error("saturated flag set without a clipped coordinate");

   a_xfer_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> v1_ff)
      else $error("accepted point did not enter the multiply stage");

endmodule

`default_nettype wire
